@@ rtl/pds_pkg.sv @@
// ----------------------------------------------------------------------------
// pds_pkg
// Shared types and constants for the pop3 dot stuffer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pds_pkg;

   // character codes
   localparam logic [7:0] CH_DOT = 8'h2E;
   localparam logic [7:0] CH_CR  = 8'h0D;
   localparam logic [7:0] CH_LF  = 8'h0A;

   // register file
   localparam int unsigned CSR_ADDR_BITS = 3;
   localparam logic        REG_TOP_MODE  = 1'b0;
   localparam logic        REG_TOP_LINES = 1'b1;
   localparam int unsigned TOP_LINES_BITS = 16;

   // pending byte slots of one item group, sent lowest slot first
   localparam int unsigned SLOT_DOT   = 0;
   localparam int unsigned SLOT_DATA  = 1;
   localparam int unsigned SLOT_T_DOT = 2;
   localparam int unsigned SLOT_T_CR  = 3;
   localparam int unsigned SLOT_T_LF  = 4;
   localparam int unsigned SLOT_COUNT = 5;

   typedef logic [SLOT_COUNT-1:0] slot_vec_type;

   // bytes caused by one accepted item
   typedef struct packed {
      logic       dot;     // stuffed leading dot
      logic       data_en; // the message byte itself
      logic [7:0] data;
      logic       term;    // terminator dot cr lf
   } group_type;

   // configuration seen by the core
   typedef struct packed {
      logic                      top_mode;
      logic [TOP_LINES_BITS-1:0] top_lines;
   } cfg_type;

endpackage

`default_nettype wire

@@ rtl/pds_if.sv @@
// ----------------------------------------------------------------------------
// pds_req_if / pds_rsp_if
// Valid/ready channels for message bytes in and response bytes out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface pds_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       byte_valid;
   logic       end_of_message;

   modport source (output valid, data_byte, byte_valid, end_of_message, input ready);
   modport sink   (input valid, data_byte, byte_valid, end_of_message, output ready);
endinterface

interface pds_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       out_last;

   modport source (output valid, out_byte, out_last, input ready);
   modport sink   (input valid, out_byte, out_last, output ready);
endinterface

`default_nettype wire

@@ rtl/pds_csr.sv @@
// ----------------------------------------------------------------------------
// pds_csr
// APB register file holding top_mode and top_lines.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pds_csr
   import pds_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_psel,
   input  wire logic                     csr_penable,
   input  wire logic                     csr_pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  wire logic [31:0]              csr_pwdata,
   output      logic [31:0]              csr_prdata,
   output      logic                     csr_pready,
   output      cfg_type                  cfg
);

   logic                      top_mode_ff;
   logic                      top_mode_in;
   logic [TOP_LINES_BITS-1:0] top_lines_ff;
   logic [TOP_LINES_BITS-1:0] top_lines_in;
   logic                      wr_en;
   logic                      reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_idx    = csr_paddr[2];

   // register writes
   always_comb begin
      top_mode_in  = top_mode_ff;
      top_lines_in = top_lines_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_TOP_MODE:  top_mode_in  = csr_pwdata[0];
            REG_TOP_LINES: top_lines_in = csr_pwdata[TOP_LINES_BITS-1:0];
            default:       top_mode_in  = top_mode_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_mode_ff  <= 1'b0;
         top_lines_ff <= '0;
      end else begin
         top_mode_ff  <= top_mode_in;
         top_lines_ff <= top_lines_in;
      end
   end

   // read back
   always_comb begin
      case (reg_idx)
         REG_TOP_MODE:  csr_prdata = {31'b0, top_mode_ff};
         REG_TOP_LINES: csr_prdata = {{(32-TOP_LINES_BITS){1'b0}}, top_lines_ff};
         default:       csr_prdata = '0;
      endcase
   end

   assign cfg.top_mode  = top_mode_ff;
   assign cfg.top_lines = top_lines_ff;

endmodule

`default_nettype wire

@@ rtl/pds_core.sv @@
// ----------------------------------------------------------------------------
// pds_core
// Line tracking state; decides which bytes each accepted item causes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pds_core
   import pds_pkg::*;
#(
   parameter int unsigned LINE_COUNT_BITS = 16
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       fire,
   input  wire logic [7:0] data_byte,
   input  wire logic       byte_valid,
   input  wire logic       end_of_message,
   input  wire cfg_type    cfg,
   output      group_type  grp
);

   localparam int unsigned CMP_BITS =
      (LINE_COUNT_BITS > TOP_LINES_BITS) ? LINE_COUNT_BITS : TOP_LINES_BITS;
   localparam logic [LINE_COUNT_BITS-1:0] CNT_MAX = '1;

   logic                       line_start_ff,  line_start_in;
   logic [1:0]                 line_pos_ff,    line_pos_in;
   logic                       first_cr_ff,    first_cr_in;
   logic                       in_body_ff,     in_body_in;
   logic [LINE_COUNT_BITS-1:0] line_cnt_ff,    line_cnt_in;
   logic                       finished_ff,    finished_in;

   logic                       take;
   logic                       empty_line;
   logic [CMP_BITS-1:0]        lines_ext;

   assign take = byte_valid & ~finished_ff;

   // bytes caused by this item
   assign grp.dot     = take & line_start_ff & (data_byte == CH_DOT);
   assign grp.data_en = take;
   assign grp.data    = data_byte;
   assign grp.term    = end_of_message;

   assign empty_line = (line_pos_ff == 2'd1) & first_cr_ff;
   assign lines_ext  = CMP_BITS'(cfg.top_lines);

   // next line state
   always_comb begin
      line_start_in = line_start_ff;
      line_pos_in   = line_pos_ff;
      first_cr_in   = first_cr_ff;
      in_body_in    = in_body_ff;
      line_cnt_in   = line_cnt_ff;
      finished_in   = finished_ff;
      if (fire && take) begin
         if (data_byte == CH_LF) begin
            if (!in_body_ff) begin
               if (empty_line) begin
                  in_body_in  = 1'b1;
                  line_cnt_in = '0;
               end
            end else if (line_cnt_ff != CNT_MAX) begin
               line_cnt_in = line_cnt_ff + 1'b1;
            end
            line_start_in = 1'b1;
            line_pos_in   = 2'd0;
            first_cr_in   = 1'b0;
         end else begin
            if (line_pos_ff == 2'd0) begin
               first_cr_in = (data_byte == CH_CR);
            end
            line_start_in = 1'b0;
            if (line_pos_ff != 2'd2) begin
               line_pos_in = line_pos_ff + 2'd1;
            end
         end
      end
      // limit check looks at the updated count
      if (fire && take && (data_byte == CH_LF) && cfg.top_mode && in_body_in &&
          (CMP_BITS'(line_cnt_in) == lines_ext)) begin
         finished_in = 1'b1;
      end
      // end of message returns to the reset state
      if (fire && end_of_message) begin
         line_start_in = 1'b1;
         line_pos_in   = 2'd0;
         first_cr_in   = 1'b0;
         in_body_in    = 1'b0;
         line_cnt_in   = '0;
         finished_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_start_ff <= 1'b1;
         line_pos_ff   <= 2'd0;
         first_cr_ff   <= 1'b0;
         in_body_ff    <= 1'b0;
         line_cnt_ff   <= '0;
         finished_ff   <= 1'b0;
      end else begin
         line_start_ff <= line_start_in;
         line_pos_ff   <= line_pos_in;
         first_cr_ff   <= first_cr_in;
         in_body_ff    <= in_body_in;
         line_cnt_ff   <= line_cnt_in;
         finished_ff   <= finished_in;
      end
   end

   // the limit can only be hit once the header is over
   a_finished_in_body: assert property (@(posedge clock) disable iff (reset)
      finished_ff |-> in_body_ff)
      else $error("finished set outside the body");

   // a fresh line has seen no bytes
   a_line_start_pos: assert property (@(posedge clock) disable iff (reset)
      line_start_ff |-> (line_pos_ff == 2'd0))
      else $error("line start with nonzero position");

   // body lines are counted only inside the body
   a_cnt_header: assert property (@(posedge clock) disable iff (reset)
      !in_body_ff |-> (line_cnt_ff == '0))
      else $error("line count moved in the header");

endmodule

`default_nettype wire

@@ rtl/pds_emit.sv @@
// ----------------------------------------------------------------------------
// pds_emit
// Holds one item's pending bytes and sends them one beat at a time
// through a registered output stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pds_emit
   import pds_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      load,
   input  wire group_type grp,
   output      logic      take_ready,
   pds_rsp_if.source      rsp
);

   slot_vec_type pend_ff, pend_in;
   logic [7:0]   data_ff, data_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [7:0]   rsp_byte_ff,  rsp_byte_in;
   logic         rsp_last_ff,  rsp_last_in;

   logic         out_free;
   logic         send;
   slot_vec_type sel;
   slot_vec_type pend_after;
   slot_vec_type grp_slots;
   logic [7:0]   sel_byte;

   assign out_free   = ~rsp_valid_ff | rsp.ready;
   assign send       = out_free & (|pend_ff);
   assign sel        = pend_ff & (~pend_ff + 1'b1);
   assign pend_after = send ? (pend_ff & ~sel) : pend_ff;
   assign take_ready = (pend_after == '0);

   always_comb begin
      grp_slots             = '0;
      grp_slots[SLOT_DOT]   = grp.dot;
      grp_slots[SLOT_DATA]  = grp.data_en;
      grp_slots[SLOT_T_DOT] = grp.term;
      grp_slots[SLOT_T_CR]  = grp.term;
      grp_slots[SLOT_T_LF]  = grp.term;
   end

   // byte for the selected slot
   always_comb begin
      case (1'b1)
         sel[SLOT_DOT]:   sel_byte = CH_DOT;
         sel[SLOT_DATA]:  sel_byte = data_ff;
         sel[SLOT_T_DOT]: sel_byte = CH_DOT;
         sel[SLOT_T_CR]:  sel_byte = CH_CR;
         sel[SLOT_T_LF]:  sel_byte = CH_LF;
         default:         sel_byte = data_ff;
      endcase
   end

   // group register
   always_comb begin
      pend_in = pend_after;
      data_in = data_ff;
      if (load) begin
         pend_in = grp_slots;
         data_in = grp.data;
      end
   end

   // output stage
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      if (send) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = sel_byte;
         rsp_last_in  = sel[SLOT_T_LF];
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      data_ff     <= data_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.out_byte = rsp_byte_ff;
   assign rsp.out_last = rsp_last_ff;

endmodule

`default_nettype wire

@@ rtl/pop3_dot_stuffer_with_top.sv @@
// ----------------------------------------------------------------------------
// pop3_dot_stuffer_with_top
// POP3 multi-line body generator: dot stuffing, header/body split,
// top line limit and the closing dot line.
// ----------------------------------------------------------------------------
//  channel  | direction | beat
//  req_chan | in        | data_byte, byte_valid, end_of_message
//  rsp_chan | out       | out_byte, out_last
//  csr_*    | apb       | top_mode (0x0), top_lines (0x4)
//
//  an item causing one byte or none is taken every cycle while rsp is not stalled
//  an item with a stuffed dot or the terminator holds req ready low until
//  its extra bytes have left the single pending group register
//  rsp is registered; a stall on rsp holds the beat and backs up into req
//  reset is synchronous and clears the line state, registers and buffers
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pop3_dot_stuffer_with_top
   import pds_pkg::*;
#(
   parameter int unsigned LINE_COUNT_BITS = 16
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   pds_req_if.sink                       req_chan,
   pds_rsp_if.source                     rsp_chan,
   input  wire logic                     csr_psel,
   input  wire logic                     csr_penable,
   input  wire logic                     csr_pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  wire logic [31:0]              csr_pwdata,
   output      logic [31:0]              csr_prdata,
   output      logic                     csr_pready
);

   cfg_type   cfg;
   group_type grp;
   logic      take_ready;
   logic      req_fire;
   logic      grp_load;

   assign req_chan.ready = take_ready;
   assign req_fire       = req_chan.valid & take_ready;
   assign grp_load       = req_fire & (grp.dot | grp.data_en | grp.term);

   pds_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   pds_core #(
      .LINE_COUNT_BITS (LINE_COUNT_BITS)
   ) u_core (
      .clock          (clock),
      .reset          (reset),
      .fire           (req_fire),
      .data_byte      (req_chan.data_byte),
      .byte_valid     (req_chan.byte_valid),
      .end_of_message (req_chan.end_of_message),
      .cfg            (cfg),
      .grp            (grp)
   );

   pds_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .load       (grp_load),
      .grp        (grp),
      .take_ready (take_ready),
      .rsp        (rsp_chan)
   );

endmodule

`default_nettype wire

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for pop3_dot_stuffer_with_top. Stored messages go in
// byte by byte over the request channel. A local model of the line tracker
// predicts the dot-stuffed response stream. Each response beat is checked
// against it in order. The run covers top mode limits set over the apb port,
// random bursts and stalls, and a long output hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
   import pds_pkg::*;

   localparam int unsigned LINE_COUNT_BITS = 16;
   localparam int unsigned CYCLE_LIMIT     = 300000;
   localparam int unsigned SETTLE_CYCLES   = 8;
   localparam int unsigned PHASE_ITEMS     = 10;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       end_of_message;
   } msg_item_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
   } resp_beat_type;

   logic                     clock;
   logic                     reset;
   logic                     csr_psel;
   logic                     csr_penable;
   logic                     csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [31:0]              csr_pwdata;
   logic [31:0]              csr_prdata;
   logic                     csr_pready;

   pds_req_if req_chan ();
   pds_rsp_if rsp_chan ();

   pop3_dot_stuffer_with_top #(
      .LINE_COUNT_BITS (LINE_COUNT_BITS)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // bench state
   resp_beat_type stuffed_q[$];
   msg_item_type  msg_q[$];
   int         mismatch_count = 0;
   int         cycle_count    = 0;
   int         items_fed      = 0;
   int         burst_left     = 0;
   int         rsp_hold_left  = 0;
   bit         steady_send    = 0;

   // model of the line tracker and registers
   logic                       cfg_top_mode  = 1'b0;
   logic [TOP_LINES_BITS-1:0]  cfg_top_lines = '0;
   logic                       at_line_start = 1'b1;
   logic [1:0]                 line_len      = 2'd0;
   logic                       line_began_cr = 1'b0;
   logic                       past_header   = 1'b0;
   logic [LINE_COUNT_BITS-1:0] body_count    = '0;
   logic                       top_reached   = 1'b0;

   // clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      mismatch_count++;
   endtask

   function automatic void expect_beat(input logic [7:0] b, input logic last);
      stuffed_q.push_back('{b, last});
   endfunction

   function automatic void clear_line_state();
      at_line_start = 1'b1;
      line_len      = 2'd0;
      line_began_cr = 1'b0;
      past_header   = 1'b0;
      body_count    = '0;
      top_reached   = 1'b0;
   endfunction

   // predict the response beats of one accepted item
   function automatic void stuff_item(input msg_item_type it);
      logic blank_line;
      if (it.byte_valid && !top_reached) begin
         if (at_line_start && it.data_byte == CH_DOT) expect_beat(CH_DOT, 1'b0);
         expect_beat(it.data_byte, 1'b0);
         if (it.data_byte == CH_LF) begin
            blank_line = (line_len == 2'd1) && line_began_cr;
            if (!past_header) begin
               if (blank_line) begin
                  past_header = 1'b1;
                  body_count  = '0;
               end
            end else if (body_count != {LINE_COUNT_BITS{1'b1}}) begin
               body_count++;
            end
            if (cfg_top_mode && past_header && body_count == cfg_top_lines)
               top_reached = 1'b1;
            at_line_start = 1'b1;
            line_len      = 2'd0;
            line_began_cr = 1'b0;
         end else begin
            if (line_len == 2'd0) line_began_cr = (it.data_byte == CH_CR);
            at_line_start = 1'b0;
            if (line_len < 2'd2) line_len++;
         end
      end
      // closing dot line
      if (it.end_of_message) begin
         expect_beat(CH_DOT, 1'b0);
         expect_beat(CH_CR, 1'b0);
         expect_beat(CH_LF, 1'b1);
         clear_line_state();
      end
   endfunction

   // ------------------------------------------------------------------
   // message building
   // ------------------------------------------------------------------
   function automatic void add_byte(input logic [7:0] b);
      msg_q.push_back('{b, 1'b1, 1'b0});
   endfunction

   function automatic void add_text(input string s);
      foreach (s[i]) add_byte(s[i]);
   endfunction

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 5))
         0: return CH_DOT;
         1: return CH_CR;
         2: return CH_LF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // one line, dot-led often, with an empty item now and then
   function automatic void add_line(input bit terminated);
      if ($urandom_range(0, 4) < 2) add_byte(CH_DOT);
      repeat ($urandom_range(0, 3)) begin
         if ($urandom_range(0, 15) == 0) msg_q.push_back('{8'($urandom), 1'b0, 1'b0});
         if ($urandom_range(0, 7) == 0) add_byte(pick_byte());
         else add_byte(8'($urandom_range(32, 126)));
      end
      if (terminated) begin
         case ($urandom_range(0, 9))
            8: add_byte(CH_LF);
            9: add_text("\r\r\n");
            default: add_text("\r\n");
         endcase
      end
   endfunction

   // end of message: on the last byte or as an empty final item
   function automatic void close_message(input bit carry);
      if (carry && msg_q.size() > 0 && msg_q[$].byte_valid)
         msg_q[$].end_of_message = 1'b1;
      else
         msg_q.push_back('{8'($urandom), 1'b0, 1'b1});
   endfunction

   function automatic void build_message();
      int hdr_n;
      int body_n;
      if ($urandom_range(0, 6) == 0) begin
         // noise: raw bytes heavy in dots and line ends
         repeat ($urandom_range(1, 10)) add_byte(pick_byte());
      end else begin
         hdr_n  = $urandom_range(0, 2);
         body_n = $urandom_range(0, 5);
         repeat (hdr_n) add_line(1'b1);
         if ($urandom_range(0, 7) != 0) add_text("\r\n");
         for (int i = 0; i < body_n; i++)
            add_line(i != body_n - 1 || $urandom_range(0, 3) != 0);
      end
      close_message($urandom_range(0, 1));
   endfunction

   // ------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------
   task automatic send_item(input msg_item_type it);
      @(negedge clock);
      req_chan.valid          <= 1'b1;
      req_chan.data_byte      <= it.data_byte;
      req_chan.byte_valid     <= it.byte_valid;
      req_chan.end_of_message <= it.end_of_message;
      do @(posedge clock); while (!req_chan.ready);
      stuff_item(it);
      // bursts with random gaps
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 15);
         if (!steady_send && $urandom_range(0, 2) != 0) begin
            @(negedge clock);
            req_chan.valid          <= 1'b0;
            req_chan.data_byte      <= 8'($urandom);
            req_chan.byte_valid     <= 1'($urandom);
            req_chan.end_of_message <= 1'($urandom);
            repeat ($urandom_range(0, 5)) @(negedge clock);
         end
      end
   endtask

   task automatic send_message();
      msg_item_type it;
      while (msg_q.size() != 0) begin
         it = msg_q.pop_front();
         send_item(it);
         if (it.byte_valid || it.end_of_message) items_fed++;
      end
   endtask

   // stop sending and let every expected beat arrive
   task automatic drain_results();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (stuffed_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // apb register access
   // ------------------------------------------------------------------
   task automatic csr_write(input logic idx, input logic [31:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_BITS'({idx, 2'b00});
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic csr_read(input logic idx, output logic [31:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= CSR_ADDR_BITS'({idx, 2'b00});
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      value = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic check_registers();
      logic [31:0] rd;
      csr_read(REG_TOP_MODE, rd);
      if (rd !== {31'b0, cfg_top_mode})
         report_mismatch($sformatf("top_mode reads %h, want %0d", rd, cfg_top_mode));
      csr_read(REG_TOP_LINES, rd);
      if (rd !== {16'b0, cfg_top_lines})
         report_mismatch($sformatf("top_lines reads %h, want %0d", rd, cfg_top_lines));
   endtask

   // upper write bits are junk that the block must ignore
   task automatic set_limits(input logic mode, input logic [15:0] lines);
      logic [31:0] wd;
      drain_results();
      wd    = $urandom;
      wd[0] = mode;
      csr_write(REG_TOP_MODE, wd);
      cfg_top_mode = mode;
      wd    = $urandom;
      wd[15:0] = lines;
      csr_write(REG_TOP_LINES, wd);
      cfg_top_lines = lines;
      check_registers();
   endtask

   // ------------------------------------------------------------------
   // response side: stall pattern, hold-off and checking
   // ------------------------------------------------------------------
   initial begin : rsp_stall
      logic [15:0] stall_pat;
      int          pat_age;
      stall_pat = '0;
      pat_age   = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_left > 0) begin
            rsp_hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            if (pat_age == 0) begin
               stall_pat = ($urandom_range(0, 3) == 0) ? 16'h0 : 16'($urandom);
               pat_age   = 32;
            end
            pat_age--;
            rsp_chan.ready <= !stall_pat[pat_age % 16];
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      resp_beat_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (stuffed_q.size() == 0) begin
            report_mismatch($sformatf("unexpected beat byte %h last %b",
                                      rsp_chan.out_byte, rsp_chan.out_last));
         end else begin
            want = stuffed_q.pop_front();
            if (rsp_chan.out_byte !== want.out_byte)
               report_mismatch($sformatf("out_byte %h, want %h",
                                         rsp_chan.out_byte, want.out_byte));
            if (rsp_chan.out_last !== want.out_last)
               report_mismatch($sformatf("out_last %b, want %b (byte %h)",
                                         rsp_chan.out_last, want.out_last, want.out_byte));
         end
      end
   end

   // watchdog
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) @(posedge clock) cycle_count++;
      $display("pop3_dot_stuffer_with_top verification failed");
      $finish;
   end

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------
   task automatic test_register_reset();
      check_registers();
   endtask

   // full message: stuffed dot, header end, empty item, byte extremes,
   // last line without line end closed by an item carrying a byte
   task automatic test_plain_stream();
      set_limits(1'b0, 16'd0);
      add_text("A\r\n\r\n.\r\n");
      msg_q.push_back('{8'h5A, 1'b0, 1'b0});
      add_byte(8'hFF);
      add_byte(8'h00);
      close_message(1'b1);
      send_message();
   endtask

   // top mode: one body line then drop, zero lines, and no header end
   task automatic test_top_limit();
      set_limits(1'b1, 16'd1);
      add_text("\r\nx\n.y\r\n");
      close_message(1'b0);
      send_message();
      set_limits(1'b1, 16'd0);
      add_text("\r\n.z");
      close_message(1'b1);
      send_message();
      add_text(".a\n");
      close_message(1'b1);
      send_message();
   endtask

   task automatic test_random_messages();
      logic [15:0] phase_lines[7];
      logic        phase_mode[7];
      int          start;
      phase_mode  = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1};
      phase_lines = '{16'd0, 16'd0, 16'd1, 16'd2, 16'hFFFF, 16'hFFFF, 16'd3};
      phase_lines[6] = 16'($urandom_range(1, 4));
      foreach (phase_mode[p]) begin
         set_limits(phase_mode[p], phase_lines[p]);
         start = items_fed;
         while (items_fed - start < PHASE_ITEMS) begin
            build_message();
            send_message();
         end
      end
   endtask

   // receiver holds off while the sender keeps offering, then the sender
   // waits for the whole backlog
   task automatic test_output_backpressure();
      int start;
      set_limits(1'b1, 16'd2);
      rsp_hold_left = 200;
      steady_send   = 1'b1;
      start = items_fed;
      while (items_fed - start < 30) begin
         build_message();
         send_message();
      end
      steady_send = 1'b0;
      drain_results();
   endtask

   // ------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------
   initial begin : main_seq
      reset                   = 1'b1;
      csr_psel                = 1'b0;
      csr_penable             = 1'b0;
      csr_pwrite              = 1'b0;
      csr_paddr               = '0;
      csr_pwdata              = '0;
      req_chan.valid          = 1'b0;
      req_chan.data_byte      = 8'h00;
      req_chan.byte_valid     = 1'b0;
      req_chan.end_of_message = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_register_reset();
      test_plain_stream();
      test_top_limit();
      test_random_messages();
      test_output_backpressure();

      drain_results();
      if (mismatch_count == 0)
         $display("pop3_dot_stuffer_with_top verification clean");
      else
         $display("pop3_dot_stuffer_with_top verification failed");
      $finish;
   end

endmodule

@@ pop3_dot_stuffer_with_top.f @@
rtl/pds_pkg.sv
rtl/pds_if.sv
rtl/pds_csr.sv
rtl/pds_core.sv
rtl/pds_emit.sv
rtl/pop3_dot_stuffer_with_top.sv
sim/tb.sv
